/* src/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  localparam int BLK_W      = 9;   // width of block index and count fields
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int MAX_WORD_W = 64;  // map bits examined per cycle

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_FORMAT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;     // capture start word/offset, read first word
    logic    adv;      // step to next word, read it
    logic    set_bit;  // mark first free bit of current word used
    logic    clr_bit;  // release addressed bit of current word
    logic    format;   // clear map and reload count
    logic    emit;     // present a result beat
    status_t status;
  } dp_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_range;   // incoming block index lies inside the map
    logic blk_zero;   // incoming block index is the header block
    logic hit;        // current word has a free bit at or after start
    logic last_word;  // current word is the last one of the map
    logic bit_used;   // addressed bit of current word is set
  } dp_sts_t;

endpackage

/* src/bba_ctrl.sv */
// Sequencer of the bitmap block allocator: decodes commands, steps the scan.
module bba_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bba_pkg::CMD_W-1:0]  in_cmd,
  input  bba_pkg::dp_sts_t           sts,
  output bba_pkg::dp_ctl_t           ctl,
  output logic                       busy
);
  import bba_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  cmd_t   in_op;

  assign in_op = cmd_t'(in_cmd);
  assign busy  = (state_r == S_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_NOP;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    ctl       = '0;
    ctl.status = STS_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_op;
          unique case (in_op)
            CMD_ALLOC: begin
              if (sts.in_range) begin
                ctl.load  = 1'b1;
                state_nxt = S_SCAN;
              end else begin
                ctl.emit   = 1'b1;
                ctl.status = STS_FULL;
              end
            end
            CMD_FREE: begin
              if (sts.in_range && !sts.blk_zero) begin
                ctl.load  = 1'b1;
                state_nxt = S_SCAN;
              end else begin
                ctl.emit   = 1'b1;
                ctl.status = STS_BAD_FREE;
              end
            end
            CMD_FORMAT: begin
              ctl.format = 1'b1;
              ctl.emit   = 1'b1;
            end
            CMD_NOP: begin
              ctl.emit = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_FREE) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
          if (sts.bit_used) ctl.clr_bit = 1'b1;
          else              ctl.status  = STS_BAD_FREE;
        end else begin
          priority if (sts.hit) begin
            ctl.set_bit = 1'b1;
            ctl.emit    = 1'b1;
            state_nxt   = S_IDLE;
          end else if (sts.last_word) begin
            ctl.emit    = 1'b1;
            ctl.status  = STS_FULL;
            state_nxt   = S_IDLE;
          end else begin
            ctl.adv = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_free_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmd_r == CMD_FREE) |=> state_r == S_IDLE)
    else $error("free scan did not finish after one word");

  a_scan_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(ctl.load))
    else $error("scan entered without loading a start word");

  a_emit_leaves_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ctl.emit) |=> !busy)
    else $error("result issued but scan continues");
`endif

endmodule

/* src/bba_dp.sv */
// Datapath of the bitmap block allocator: word map, row valid bits, count, results.
module bba_dp #(
  parameter int NUM_BLOCKS = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bba_pkg::BLK_W-1:0]     in_block,
  input  bba_pkg::dp_ctl_t              ctl,
  output bba_pkg::dp_sts_t              sts,
  output logic                          out_valid,
  output logic [bba_pkg::STATUS_W-1:0]  out_status,
  output logic [bba_pkg::BLK_W-1:0]     out_found_block,
  output logic [bba_pkg::BLK_W-1:0]     out_free_count
);
  import bba_pkg::*;

  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int WORD_W    = (NUM_BLOCKS >= MAX_WORD_W) ? MAX_WORD_W : (2 ** IDX_W);
  localparam int OFF_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam int XW        = ((IDX_W > BLK_W) ? IDX_W : BLK_W) + 1;
  localparam int CW        = IDX_W;
  localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [CW-1:0]     CNT_INIT  = CW'(NUM_BLOCKS - 1);
  localparam logic [WORD_W-1:0] PAD_MASK  = {WORD_W{1'b1}} << LAST_BITS;
  localparam logic [WORD_W-1:0] HDR_ROW   = WORD_W'(1);

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [WORD_W-1:0] rdata_r;
  logic              rvld_r;
  logic [NUM_WORDS-1:0] vld_r, vld_nxt;

  logic [AW-1:0]    cur_r, cur_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             first_r, first_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BLK_W-1:0]    out_found_r, out_found_nxt;
  logic [BLK_W-1:0]    out_count_r, out_count_nxt;

  logic [XW-1:0]       blk_x;
  logic [AW-1:0]       in_word;
  logic [OFF_W-1:0]    in_off;
  logic [AW-1:0]       raddr;
  logic                rd_en;
  logic [WORD_W-1:0]   word;
  logic [WORD_W-1:0]   masked;
  logic [OFF_W-1:0]    hit_off;
  logic                we;
  logic [WORD_W-1:0]   wdata;
  logic [AW+OFF_W+BLK_W-1:0] found_ext;
  logic [CW+BLK_W-1:0]       count_ext;

  assign blk_x   = XW'(in_block);
  assign in_word = blk_x[OFF_W +: AW];
  assign in_off  = blk_x[OFF_W-1:0];

  assign sts.in_range = (blk_x < XW'(NUM_BLOCKS));
  assign sts.blk_zero = (in_block == '0);

  // Never-written rows read as their reset contents.
  assign word = rvld_r ? rdata_r : ((cur_r == '0) ? HDR_ROW : '0);

  // Treat bits below the start offset and past the map end as used.
  always_comb begin
    masked = word;
    if (first_r)            masked = masked | ~({WORD_W{1'b1}} << off_r);
    if (cur_r == LAST_WORD) masked = masked | PAD_MASK;
  end

  always_comb begin
    hit_off = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!masked[i]) hit_off = OFF_W'(i);
    end
  end

  assign sts.hit       = ~&masked;
  assign sts.last_word = (cur_r == LAST_WORD);
  assign sts.bit_used  = word[off_r];

  assign rd_en = ctl.load || ctl.adv;
  assign raddr = ctl.load ? in_word : cur_r + AW'(1);

  assign we = ctl.set_bit || ctl.clr_bit;
  always_comb begin
    if (ctl.set_bit) wdata = word | (WORD_W'(1) << hit_off);
    else             wdata = word & ~(WORD_W'(1) << off_r);
  end

  always_ff @(posedge clk) begin
    if (we) mem[cur_r] <= wdata;
    if (rd_en) begin
      rdata_r <= mem[raddr];
      rvld_r  <= vld_r[raddr];
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    off_nxt   = off_r;
    first_nxt = first_r;
    if (ctl.load) begin
      cur_nxt   = in_word;
      off_nxt   = in_off;
      first_nxt = 1'b1;
    end else if (ctl.adv) begin
      cur_nxt   = cur_r + AW'(1);
      first_nxt = 1'b0;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    cnt_nxt = cnt_r;
    priority if (ctl.format) begin
      vld_nxt = '0;
      cnt_nxt = CNT_INIT;
    end else if (ctl.set_bit) begin
      vld_nxt[cur_r] = 1'b1;
      if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
    end else if (ctl.clr_bit) begin
      vld_nxt[cur_r] = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign found_ext     = {{BLK_W{1'b0}}, cur_r, hit_off};
  assign count_ext     = {{BLK_W{1'b0}}, cnt_nxt};
  assign out_found_nxt = ctl.set_bit ? found_ext[BLK_W-1:0] : '0;
  assign out_count_nxt = count_ext[BLK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cnt_r       <= CNT_INIT;
      cur_r       <= '0;
      off_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      off_r       <= off_nxt;
      first_r     <= first_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  // Hold result payload until the next beat.
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status_r <= ctl.status;
      out_found_r  <= out_found_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_block = out_found_r;
  assign out_free_count  = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_INIT)
    else $error("free count exceeds map size");

  a_set_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.set_bit |-> sts.hit)
    else $error("allocation without a free bit");

  a_format_reload: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.format |=> (cnt_r == CNT_INIT && vld_r == '0))
    else $error("format did not reload map state");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.set_bit && ctl.clr_bit))
    else $error("set and clear in the same cycle");
`endif

endmodule

/* src/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator.
//
// Usage: drive in_cmd/in_block and raise start; the command beat is taken at
// a clock edge where start is high and busy is low. Commands: allocate the
// first free block at or after in_block, free in_block, format the map, or
// no operation. Every command yields exactly one result beat on out_status,
// out_found_block and out_free_count, marked by out_valid for one cycle.
// The receiver cannot stall; out_valid is high for one cycle only and the
// payload holds until the next beat. Format, no operation and rejected
// commands answer in the cycle after acceptance. Free reads the addressed
// word, then checks and updates it. Allocate scans map words, 64 bits wide in
// the default map of 8 words, from the one holding in_block to the last, one
// word per cycle from a single-port word memory; busy is high during the
// scan and a new command may be accepted while the previous result is shown.
// Reset: synchronous, active low; the map reads as only block 0 used and the
// free count is NUM_BLOCKS-1 right after reset, with no clearing pass.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bba_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bba_pkg::BLK_W-1:0]     in_block,
  output logic                          out_valid,
  output logic [bba_pkg::STATUS_W-1:0]  out_status,
  output logic [bba_pkg::BLK_W-1:0]     out_found_block,
  output logic [bba_pkg::BLK_W-1:0]     out_free_count
);
  import bba_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  bba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_block        (in_block),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_block (out_found_block),
    .out_free_count  (out_free_count)
  );

endmodule
